/* hw/rtl/rwst_pkg.sv */
package rwst_pkg;

  localparam int WIN_MAX     = 32;
  localparam int IDX_W       = $clog2(WIN_MAX);
  localparam int CNT_W       = $clog2(WIN_MAX + 1);
  localparam int SAMPLE_W    = 8;
  localparam int WSIZE_W     = 6;
  localparam int THR_W       = 15;
  localparam int CFG_DATA_W  = 15;
  localparam int CFG_IDX_W   = 1;
  localparam int TREND_W     = 2;
  localparam int SLOPE_W     = 16;
  localparam int MIN_SAMPLES = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam int SX_W     = 9;
  localparam int SX2_W    = 14;
  localparam int SY_W     = 14;
  localparam int SXY_W    = 18;
  localparam int NUM_W    = 24;
  localparam int PDEN_W   = 20;
  localparam int DEN_W    = 17;
  localparam int FRAC_W   = 8;
  localparam int DIVD_W   = NUM_W + FRAC_W;
  localparam int THRD_W   = THR_W + DEN_W;
  localparam int DIVCNT_W = $clog2(DIVD_W);

  localparam logic [CNT_W-1:0]   WIN_MAX_C  = CNT_W'(WIN_MAX);
  localparam logic [WSIZE_W-1:0] WSIZE_RST  = WSIZE_W'(10);
  localparam logic [THR_W-1:0]   THR_RST    = THR_W'(256);
  localparam logic [DIVD_W-1:0]  Q_POS_LIM  = DIVD_W'(2 ** (SLOPE_W - 1) - 1);
  localparam logic [DIVD_W-1:0]  Q_NEG_LIM  = DIVD_W'(2 ** (SLOPE_W - 1));
  localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W - 1){1'b1}}};
  localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W - 1){1'b0}}};

  typedef enum logic [TREND_W-1:0] {
    TREND_FLAT    = 2'd0,
    TREND_FALLING = 2'd1,
    TREND_RISING  = 2'd2
  } trend_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SIZE     = 1'b0,
    CFG_SLOPE_THRESHOLD = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [WSIZE_W-1:0] window_size;
    logic [THR_W-1:0]   slope_threshold;
  } cfg_t;

  typedef struct packed {
    logic                has_reading;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

endpackage

/* hw/rtl/rwst_in_if.sv */
interface rwst_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rwst_pkg::SAMPLE_W-1:0] sample_dbm;

  modport source (output valid, output sample_dbm, input ready);
  modport sink (input valid, input sample_dbm, output ready);
endinterface

/* hw/rtl/rwst_out_if.sv */
interface rwst_out_if;
  logic                               valid;
  logic                               ready;
  logic [rwst_pkg::TREND_W-1:0]        trend_code;
  logic signed [rwst_pkg::SLOPE_W-1:0] slope_q8;

  modport source (output valid, output trend_code, output slope_q8, input ready);
  modport sink (input valid, input trend_code, input slope_q8, output ready);
endinterface

/* hw/rtl/rwst_front.sv */
module rwst_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rwst_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rwst_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rwst_in_if.sink                        sample_in_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output rwst_pkg::item_t                item_o,
  output rwst_pkg::cfg_t                 cfg_o
);

  logic [rwst_pkg::WSIZE_W-1:0] window_size_q;
  logic [rwst_pkg::THR_W-1:0]   slope_threshold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q     <= rwst_pkg::WSIZE_RST;
      slope_threshold_q <= rwst_pkg::THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rwst_pkg::CFG_WINDOW_SIZE: begin
          window_size_q <= cfg_data_i[rwst_pkg::WSIZE_W-1:0];
        end
        rwst_pkg::CFG_SLOPE_THRESHOLD: begin
          slope_threshold_q <= cfg_data_i[rwst_pkg::THR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign sample_in_i.ready  = !q_full_i;
  assign push_o             = sample_in_i.valid && !q_full_i;
  assign item_o.has_reading = (sample_in_i.sample_dbm != '0);
  assign item_o.sample      = sample_in_i.sample_dbm;

  assign cfg_o.window_size     = window_size_q;
  assign cfg_o.slope_threshold = slope_threshold_q;

endmodule

/* hw/rtl/rwst_queue.sv */
module rwst_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rwst_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output rwst_pkg::item_t item_o,
  output logic            empty_o
);

  localparam int PTR_W = (rwst_pkg::QUEUE_DEPTH > 1) ? $clog2(rwst_pkg::QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(rwst_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(rwst_pkg::QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(rwst_pkg::QUEUE_DEPTH);

  rwst_pkg::item_t    entry_q [rwst_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* hw/rtl/rwst_back.sv */
module rwst_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rwst_pkg::cfg_t  cfg_i,
  input  logic            empty_i,
  input  rwst_pkg::item_t item_i,
  output logic            pop_o,
  rwst_out_if.source      result_out_o
);

  typedef enum logic [3:0] {
    B_IDLE,
    B_STORE,
    B_START,
    B_WALK,
    B_MUL,
    B_SUB,
    B_THR,
    B_DIV,
    B_OUT
  } state_e;

  state_e                               state_q, state_d;
  rwst_pkg::item_t                      item_q, item_d;
  logic [rwst_pkg::CNT_W-1:0]           count_q, count_d;
  logic [rwst_pkg::IDX_W-1:0]           oldest_q, oldest_d;
  logic [rwst_pkg::CNT_W-1:0]           rd_i_q, rd_i_d;
  logic                                 pend_q, pend_d;
  logic [rwst_pkg::IDX_W-1:0]           pend_x_q, pend_x_d;
  logic [rwst_pkg::SX_W-1:0]            sx_q, sx_d;
  logic [rwst_pkg::SX2_W-1:0]           sx2_q, sx2_d;
  logic signed [rwst_pkg::SY_W-1:0]     sy_q, sy_d;
  logic signed [rwst_pkg::SXY_W-1:0]    sxy_q, sxy_d;
  logic signed [rwst_pkg::NUM_W-1:0]    pa_q, pa_d;
  logic signed [rwst_pkg::NUM_W-1:0]    pb_q, pb_d;
  logic [rwst_pkg::PDEN_W-1:0]          pc_q, pc_d;
  logic [rwst_pkg::PDEN_W-1:0]          pd_q, pd_d;
  logic                                 neg_q, neg_d;
  logic [rwst_pkg::NUM_W-1:0]           mag_q, mag_d;
  logic [rwst_pkg::DEN_W-1:0]           den_q, den_d;
  logic [rwst_pkg::THRD_W-1:0]          thrd_q, thrd_d;
  logic [rwst_pkg::DEN_W-1:0]           rem_q, rem_d;
  logic [rwst_pkg::DIVD_W-1:0]          divq_q, divq_d;
  logic [rwst_pkg::DIVCNT_W-1:0]        div_cnt_q, div_cnt_d;
  logic                                 short_q, short_d;
  logic                                 out_valid_q, out_valid_d;
  rwst_pkg::trend_e                     trend_q, trend_d;
  logic signed [rwst_pkg::SLOPE_W-1:0]  slope_q, slope_d;

  logic [rwst_pkg::SAMPLE_W-1:0]        ring [rwst_pkg::WIN_MAX];
  logic [rwst_pkg::SAMPLE_W-1:0]        rdata_q;
  logic                                 wr_en;
  logic [rwst_pkg::IDX_W-1:0]           wr_addr;
  logic [rwst_pkg::IDX_W-1:0]           rd_addr;

  logic [rwst_pkg::CNT_W-1:0]           lim, c1, drop;
  logic [rwst_pkg::IDX_W-1:0]           o1;
  logic signed [rwst_pkg::SAMPLE_W-1:0] y;
  logic signed [rwst_pkg::SXY_W-1:0]    xs, ys;
  logic [rwst_pkg::SX2_W-1:0]           xe;
  logic signed [rwst_pkg::NUM_W-1:0]    n_s, sxy_s, sx_s, sy_s, num;
  logic [rwst_pkg::PDEN_W-1:0]          n_u, sx2_u, sx_u, den_full;
  logic [rwst_pkg::DEN_W:0]             rem_sh;
  logic                                 rem_ge;
  logic [rwst_pkg::DIVD_W-1:0]          mag_sh;
  logic                                 out_free;

  assign pop_o    = (state_q == B_IDLE) && !empty_i;
  assign out_free = !out_valid_q || result_out_o.ready;

  always_comb begin
    lim = (cfg_i.window_size > rwst_pkg::WIN_MAX_C) ? rwst_pkg::WIN_MAX_C : cfg_i.window_size;
    if (count_q < rwst_pkg::WIN_MAX_C) begin
      wr_addr = oldest_q + count_q[rwst_pkg::IDX_W-1:0];
      c1      = count_q + rwst_pkg::CNT_W'(1);
      o1      = oldest_q;
    end else begin
      wr_addr = oldest_q;
      c1      = count_q;
      o1      = oldest_q + rwst_pkg::IDX_W'(1);
    end
    drop     = c1 - lim;
    rd_addr  = oldest_q + rd_i_q[rwst_pkg::IDX_W-1:0];
    y        = signed'(rdata_q);
    xs       = rwst_pkg::SXY_W'(signed'({1'b0, pend_x_q}));
    ys       = rwst_pkg::SXY_W'(y);
    xe       = rwst_pkg::SX2_W'(pend_x_q);
    n_s      = rwst_pkg::NUM_W'(signed'({1'b0, count_q}));
    sxy_s    = rwst_pkg::NUM_W'(sxy_q);
    sx_s     = rwst_pkg::NUM_W'(signed'({1'b0, sx_q}));
    sy_s     = rwst_pkg::NUM_W'(sy_q);
    n_u      = rwst_pkg::PDEN_W'(count_q);
    sx2_u    = rwst_pkg::PDEN_W'(sx2_q);
    sx_u     = rwst_pkg::PDEN_W'(sx_q);
    num      = pa_q - pb_q;
    den_full = pc_q - pd_q;
    rem_sh   = {rem_q, divq_q[rwst_pkg::DIVD_W-1]};
    rem_ge   = (rem_sh >= {1'b0, den_q});
    mag_sh   = {mag_q, {rwst_pkg::FRAC_W{1'b0}}};

    state_d     = state_q;
    item_d      = item_q;
    count_d     = count_q;
    oldest_d    = oldest_q;
    rd_i_d      = rd_i_q;
    pend_d      = pend_q;
    pend_x_d    = pend_x_q;
    sx_d        = sx_q;
    sx2_d       = sx2_q;
    sy_d        = sy_q;
    sxy_d       = sxy_q;
    pa_d        = pa_q;
    pb_d        = pb_q;
    pc_d        = pc_q;
    pd_d        = pd_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    den_d       = den_q;
    thrd_d      = thrd_q;
    rem_d       = rem_q;
    divq_d      = divq_q;
    div_cnt_d   = div_cnt_q;
    short_d     = short_q;
    out_valid_d = out_valid_q && !result_out_o.ready;
    trend_d     = trend_q;
    slope_d     = slope_q;
    wr_en       = 1'b0;

    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          item_d  = item_i;
          state_d = B_STORE;
        end
      end
      B_STORE: begin
        if (item_q.has_reading) begin
          wr_en = 1'b1;
          if (c1 > lim) begin
            count_d  = lim;
            oldest_d = o1 + drop[rwst_pkg::IDX_W-1:0];
          end else begin
            count_d  = c1;
            oldest_d = o1;
          end
        end
        state_d = B_START;
      end
      B_START: begin
        if (count_q < rwst_pkg::CNT_W'(rwst_pkg::MIN_SAMPLES)) begin
          short_d = 1'b1;
          state_d = B_OUT;
        end else begin
          short_d = 1'b0;
          rd_i_d  = '0;
          pend_d  = 1'b0;
          sx_d    = '0;
          sx2_d   = '0;
          sy_d    = '0;
          sxy_d   = '0;
          state_d = B_WALK;
        end
      end
      B_WALK: begin
        if (pend_q) begin
          sx_d  = sx_q + rwst_pkg::SX_W'(pend_x_q);
          sx2_d = sx2_q + xe * xe;
          sy_d  = sy_q + rwst_pkg::SY_W'(y);
          sxy_d = sxy_q + xs * ys;
        end
        if (rd_i_q < count_q) begin
          pend_d   = 1'b1;
          pend_x_d = rd_i_q[rwst_pkg::IDX_W-1:0];
          rd_i_d   = rd_i_q + rwst_pkg::CNT_W'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = B_MUL;
          end
        end
      end
      B_MUL: begin
        pa_d    = n_s * sxy_s;
        pb_d    = sx_s * sy_s;
        pc_d    = n_u * sx2_u;
        pd_d    = sx_u * sx_u;
        state_d = B_SUB;
      end
      B_SUB: begin
        neg_d   = num[rwst_pkg::NUM_W-1];
        mag_d   = num[rwst_pkg::NUM_W-1] ? unsigned'(-num) : unsigned'(num);
        den_d   = den_full[rwst_pkg::DEN_W-1:0];
        state_d = B_THR;
      end
      B_THR: begin
        thrd_d    = rwst_pkg::THRD_W'(cfg_i.slope_threshold) * rwst_pkg::THRD_W'(den_q);
        rem_d     = '0;
        divq_d    = mag_sh;
        div_cnt_d = '0;
        state_d   = B_DIV;
      end
      B_DIV: begin
        rem_d     = rem_ge ? rwst_pkg::DEN_W'(rem_sh - {1'b0, den_q})
                           : rem_sh[rwst_pkg::DEN_W-1:0];
        divq_d    = {divq_q[rwst_pkg::DIVD_W-2:0], rem_ge};
        div_cnt_d = div_cnt_q + rwst_pkg::DIVCNT_W'(1);
        if (div_cnt_q == rwst_pkg::DIVCNT_W'(rwst_pkg::DIVD_W - 1)) begin
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (short_q) begin
            trend_d = rwst_pkg::TREND_FLAT;
            slope_d = '0;
          end else begin
            if (mag_sh > rwst_pkg::DIVD_W'(thrd_q)) begin
              trend_d = neg_q ? rwst_pkg::TREND_FALLING : rwst_pkg::TREND_RISING;
            end else begin
              trend_d = rwst_pkg::TREND_FLAT;
            end
            if (neg_q) begin
              slope_d = (divq_q > rwst_pkg::Q_NEG_LIM) ? rwst_pkg::SLOPE_MIN
                      : signed'(rwst_pkg::SLOPE_W'(-divq_q[rwst_pkg::SLOPE_W-1:0]));
            end else begin
              slope_d = (divq_q > rwst_pkg::Q_POS_LIM) ? rwst_pkg::SLOPE_MAX
                      : signed'(divq_q[rwst_pkg::SLOPE_W-1:0]);
            end
          end
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      item_q      <= '0;
      count_q     <= '0;
      oldest_q    <= '0;
      rd_i_q      <= '0;
      pend_q      <= 1'b0;
      pend_x_q    <= '0;
      sx_q        <= '0;
      sx2_q       <= '0;
      sy_q        <= '0;
      sxy_q       <= '0;
      pa_q        <= '0;
      pb_q        <= '0;
      pc_q        <= '0;
      pd_q        <= '0;
      neg_q       <= 1'b0;
      mag_q       <= '0;
      den_q       <= '0;
      thrd_q      <= '0;
      rem_q       <= '0;
      divq_q      <= '0;
      div_cnt_q   <= '0;
      short_q     <= 1'b0;
      out_valid_q <= 1'b0;
      trend_q     <= rwst_pkg::TREND_FLAT;
      slope_q     <= '0;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      count_q     <= count_d;
      oldest_q    <= oldest_d;
      rd_i_q      <= rd_i_d;
      pend_q      <= pend_d;
      pend_x_q    <= pend_x_d;
      sx_q        <= sx_d;
      sx2_q       <= sx2_d;
      sy_q        <= sy_d;
      sxy_q       <= sxy_d;
      pa_q        <= pa_d;
      pb_q        <= pb_d;
      pc_q        <= pc_d;
      pd_q        <= pd_d;
      neg_q       <= neg_d;
      mag_q       <= mag_d;
      den_q       <= den_d;
      thrd_q      <= thrd_d;
      rem_q       <= rem_d;
      divq_q      <= divq_d;
      div_cnt_q   <= div_cnt_d;
      short_q     <= short_d;
      out_valid_q <= out_valid_d;
      trend_q     <= trend_d;
      slope_q     <= slope_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring[wr_addr] <= item_q.sample;
    end
    rdata_q <= ring[rd_addr];
  end

  assign result_out_o.valid      = out_valid_q;
  assign result_out_o.trend_code = trend_q;
  assign result_out_o.slope_q8   = slope_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rwst_pkg::WIN_MAX_C)
    else $error("Window count exceeds the ring depth.");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_WALK) |-> (rd_i_q <= count_q))
    else $error("Window walk ran past the sample count.");

  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV) |-> (den_q != '0))
    else $error("Division started with a zero denominator.");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV) |-> (rem_q < den_q))
    else $error("Partial remainder is not below the denominator.");
`endif

endmodule

/* hw/rtl/rssi_window_slope_trend_unit.sv */
// With three or more stored samples, the result beat for an accepted beat comes after a
// serial walk of the sample ring and then a 32-step restoring divide.
// With fewer than three samples the walk and divide are skipped.
// The back end works on one beat at a time through the serial walk and the divider;
// a two-entry queue takes further input beats while the back end is busy.
// Reset clears the window count, ring pointer, queue and handshakes and loads default config.
module rssi_window_slope_trend_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rwst_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rwst_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rwst_in_if.sink                        sample_in_i,
  rwst_out_if.source                     result_out_o
);

  rwst_pkg::cfg_t  cfg;
  rwst_pkg::item_t push_item;
  rwst_pkg::item_t pop_item;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  rwst_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_in_i (sample_in_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (push_item),
    .cfg_o       (cfg)
  );

  rwst_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (q_empty)
  );

  rwst_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .empty_i      (q_empty),
    .item_i       (pop_item),
    .pop_o        (pop),
    .result_out_o (result_out_o)
  );

endmodule
